// ----- rtl/i2c_ras_pkg.sv -----
// Package for the I2C master register-access sequencer.
// Holds the phase encoding, action codes, field selectors and the item/result
// structs. No dependencies.
`default_nettype none

package i2c_ras_pkg;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_SB_W      = 4'd1,
        PH_ADDR_W    = 4'd2,
        PH_BTF_WR    = 4'd3,
        PH_BTF_RS    = 4'd4,
        PH_SB_R      = 4'd5,
        PH_ADDR_R    = 4'd6,
        PH_RX_ONE    = 4'd7,
        PH_BTF_TWO   = 4'd8,
        PH_BTF_MANY  = 4'd9,
        PH_BTF_THREE = 4'd10,
        PH_RX_LAST   = 4'd11
    } phase_t;

    // Request kinds
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_STATUS = 1'b1;

    // Action codes for ACK, POS and buffer interrupt control
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_ON   = 2'd1;
    localparam logic [1:0] ACT_OFF  = 2'd2;

    // Status flag bit positions
    localparam int FL_START_SENT = 0;
    localparam int FL_ADDR_ACK   = 1;
    localparam int FL_RX_NE      = 2;
    localparam int FL_BYTE_DONE  = 3;
    localparam int FL_TX_EMPTY   = 4;

    // Result slots per item
    localparam int MAX_RES = 4;

    // Result fields that may force a new result when set twice
    typedef enum logic [2:0] {
        F_DRV   = 3'd0,
        F_START = 3'd1,
        F_STOP  = 3'd2,
        F_ACK   = 3'd3,
        F_POS   = 3'd4,
        F_BUF   = 3'd5,
        F_RXV   = 3'd6
    } fld_t;

    typedef struct packed {
        logic       req_type;
        logic [6:0] slave_addr;
        logic [7:0] reg_addr;
        logic [7:0] xfer_len;
        logic       is_read;
        logic [4:0] status_flags;
        logic [7:0] rx_first;
        logic [7:0] rx_second;
        logic [7:0] tx_byte;
    } item_t;

    typedef struct packed {
        logic       dr_write_valid;
        logic [7:0] dr_write_value;
        logic       gen_start;
        logic       gen_stop;
        logic [1:0] ack_action;
        logic [1:0] pos_action;
        logic [1:0] buf_irq_action;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_taken;
        logic       busy_res;
        logic       last;
    } result_t;

    // Results built for one item, with their count (0..MAX_RES)
    typedef struct packed {
        result_t [MAX_RES-1:0] r;
        logic    [2:0]         n;
    } pack_t;

    // Index of the newest open result
    function automatic logic [1:0] top_idx(logic [2:0] n);
        logic [2:0] t;
        t = n - 3'd1;
        return t[1:0];
    endfunction

    // Set one field; open a new result first if that field is already in use
    function automatic pack_t put(pack_t p, fld_t f, logic [1:0] v);
        logic [1:0] top;
        logic       occ;
        top = top_idx(p.n);
        case (f)
            F_DRV:   occ = p.r[top].dr_write_valid;
            F_START: occ = p.r[top].gen_start;
            F_STOP:  occ = p.r[top].gen_stop;
            F_ACK:   occ = (p.r[top].ack_action != ACT_NONE);
            F_POS:   occ = (p.r[top].pos_action != ACT_NONE);
            F_BUF:   occ = (p.r[top].buf_irq_action != ACT_NONE);
            F_RXV:   occ = p.r[top].rx_valid;
            default: occ = 1'b0;
        endcase
        if ((p.n == 3'd0 || occ) && p.n < 3'(MAX_RES)) begin
            p.r[p.n[1:0]] = '0;
            p.n = p.n + 3'd1;
        end
        top = top_idx(p.n);
        case (f)
            F_DRV:   p.r[top].dr_write_valid = v[0];
            F_START: p.r[top].gen_start      = v[0];
            F_STOP:  p.r[top].gen_stop       = v[0];
            F_ACK:   p.r[top].ack_action     = v;
            F_POS:   p.r[top].pos_action     = v;
            F_BUF:   p.r[top].buf_irq_action = v;
            F_RXV:   p.r[top].rx_valid       = v[0];
            default: ;
        endcase
        return p;
    endfunction

    // Data register write: valid flag plus byte
    function automatic pack_t put_dr(pack_t p, logic [7:0] b);
        pack_t q;
        q = put(p, F_DRV, 2'd1);
        q.r[top_idx(q.n)].dr_write_value = b;
        return q;
    endfunction

    // Received byte: valid flag plus byte
    function automatic pack_t put_rx(pack_t p, logic [7:0] b);
        pack_t q;
        q = put(p, F_RXV, 2'd1);
        q.r[top_idx(q.n)].rx_byte = b;
        return q;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/i2c_master_register_access_sequencer.sv -----
// I2C master register-access sequencer, top level.
// Uses i2c_ras_pkg for phase encoding, action codes and result packing.
//
// Usage:
//   Input channel (in_valid/in_ready): one transaction is either a start request
//   (req_type 0, with slave_addr, reg_addr, xfer_len, is_read) or a status event
//   from the I2C engine (req_type 1, with status_flags, rx_first, rx_second,
//   tx_byte). Output channel (out_valid/out_ready): each input transaction gives
//   one to three result transactions; the final one has last set.
// Path: an accepted item is held in the input register, decoded
//   combinationally in one pass, and loaded into the result stage, whose
//   slot 0 drives the output.
// Throughput: one item per cycle while every item yields a single result and
//   out_ready is high; an item with several results holds the result stage
//   until all are out, shifting one result per cycle while out_ready is high.
// Stall: while out_ready is low the result stage holds; the input register still
//   takes one more item, then in_ready drops until the result stage frees up.
// Reset: phase returns to idle, the latched transfer fields clear, and both
//   the input register and the result stage are emptied.
`default_nettype none

module i2c_master_register_access_sequencer
    import i2c_ras_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       req_type,
    input  wire logic [6:0] slave_addr,
    input  wire logic [7:0] reg_addr,
    input  wire logic [7:0] xfer_len,
    input  wire logic       is_read,
    input  wire logic [4:0] status_flags,
    input  wire logic [7:0] rx_first,
    input  wire logic [7:0] rx_second,
    input  wire logic [7:0] tx_byte,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            dr_write_valid,
    output logic [7:0]      dr_write_value,
    output logic            gen_start,
    output logic            gen_stop,
    output logic [1:0]      ack_action,
    output logic [1:0]      pos_action,
    output logic [1:0]      buf_irq_action,
    output logic            rx_valid,
    output logic [7:0]      rx_byte,
    output logic            tx_taken,
    output logic            busy_res,
    output logic            last
);

    // Input register
    logic    in_valid_reg;
    item_t   in_reg;

    // Transfer state
    phase_t  phase_reg, phase_next;
    logic [6:0] slave_addr_reg, slave_addr_next;
    logic [7:0] reg_addr_reg, reg_addr_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic       read_mode_reg, read_mode_next;

    // Result stage
    result_t [MAX_RES-1:0] res_reg;
    logic    [2:0]         res_cnt_reg;

    pack_t   pk;
    logic    hold_free;
    logic    load;
    logic    fire_out;

    // Handshake
    assign out_valid = (res_cnt_reg != 3'd0);
    assign fire_out  = out_valid && out_ready;
    assign hold_free = (res_cnt_reg == 3'd0) || (res_cnt_reg == 3'd1 && out_ready);
    assign load      = in_valid_reg && hold_free;
    assign in_ready  = !in_valid_reg || load;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg.req_type     <= req_type;
            in_reg.slave_addr   <= slave_addr;
            in_reg.reg_addr     <= reg_addr;
            in_reg.xfer_len     <= xfer_len;
            in_reg.is_read      <= is_read;
            in_reg.status_flags <= status_flags;
            in_reg.rx_first     <= rx_first;
            in_reg.rx_second    <= rx_second;
            in_reg.tx_byte      <= tx_byte;
        end
    end

    // Decode one item: next state and its packed results
    always_comb
    begin
        phase_next      = phase_reg;
        slave_addr_next = slave_addr_reg;
        reg_addr_next   = reg_addr_reg;
        bytes_left_next = bytes_left_reg;
        read_mode_next  = read_mode_reg;
        pk              = '0;

        if (in_reg.req_type == REQ_START)
        begin
            // Start request; ignored unless idle
            if (phase_reg == PH_IDLE)
            begin
                slave_addr_next = in_reg.slave_addr;
                reg_addr_next   = in_reg.reg_addr;
                bytes_left_next = in_reg.xfer_len;
                read_mode_next  = in_reg.is_read;
                if (in_reg.is_read)
                begin
                    pk = put(pk, F_ACK, ACT_ON);
                    pk = put(pk, F_POS, ACT_OFF);
                end
                pk = put(pk, F_START, 2'd1);
                phase_next = PH_SB_W;
            end
        end
        else
        begin
            // Start condition sent: address byte
            if (in_reg.status_flags[FL_START_SENT])
            begin
                if (phase_next == PH_SB_W)
                begin
                    pk = put_dr(pk, {slave_addr_reg, 1'b0});
                    phase_next = PH_ADDR_W;
                end
                else if (phase_next == PH_SB_R)
                begin
                    pk = put_dr(pk, {slave_addr_reg, 1'b1});
                    phase_next = PH_ADDR_R;
                end
            end

            // Address acked: register byte, or pick the read ending
            if (in_reg.status_flags[FL_ADDR_ACK])
            begin
                if (phase_next == PH_ADDR_R)
                begin
                    if (bytes_left_reg == 8'd1)
                    begin
                        pk = put(pk, F_ACK, ACT_OFF);
                        pk = put(pk, F_STOP, 2'd1);
                        pk = put(pk, F_BUF, ACT_ON);
                        phase_next = PH_RX_ONE;
                    end
                    else if (bytes_left_reg == 8'd2)
                    begin
                        pk = put(pk, F_POS, ACT_ON);
                        pk = put(pk, F_ACK, ACT_OFF);
                        phase_next = PH_BTF_TWO;
                    end
                    else if (bytes_left_reg == 8'd3)
                    begin
                        phase_next = PH_BTF_THREE;
                    end
                    else
                    begin
                        phase_next = PH_BTF_MANY;
                    end
                end
                else if (phase_next == PH_ADDR_W)
                begin
                    pk = put_dr(pk, reg_addr_reg);
                    phase_next = read_mode_reg ? PH_BTF_RS : PH_BTF_WR;
                end
            end

            // Rx not empty: last byte of a read; buffer irq always disabled
            if (in_reg.status_flags[FL_RX_NE])
            begin
                if (phase_next == PH_RX_ONE || phase_next == PH_RX_LAST)
                begin
                    pk = put_rx(pk, in_reg.rx_first);
                    phase_next = PH_IDLE;
                end
                pk = put(pk, F_BUF, ACT_OFF);
            end

            // Byte transfer finished
            if (in_reg.status_flags[FL_BYTE_DONE])
            begin
                case (phase_next)
                    PH_BTF_TWO:
                    begin
                        pk = put(pk, F_STOP, 2'd1);
                        pk = put_rx(pk, in_reg.rx_first);
                        pk = put_rx(pk, in_reg.rx_second);
                        phase_next = PH_IDLE;
                    end
                    PH_BTF_MANY:
                    begin
                        pk = put_rx(pk, in_reg.rx_first);
                        bytes_left_next = bytes_left_reg - 8'd1;
                        if (bytes_left_next <= 8'd3)
                        begin
                            phase_next = PH_BTF_THREE;
                        end
                    end
                    PH_BTF_THREE:
                    begin
                        pk = put(pk, F_ACK, ACT_OFF);
                        pk = put_rx(pk, in_reg.rx_first);
                        pk = put(pk, F_STOP, 2'd1);
                        pk = put_rx(pk, in_reg.rx_second);
                        pk = put(pk, F_BUF, ACT_ON);
                        phase_next = PH_RX_LAST;
                    end
                    PH_BTF_WR:
                    begin
                        if (bytes_left_reg != 8'd0 && in_reg.status_flags[FL_TX_EMPTY])
                        begin
                            pk = put_dr(pk, in_reg.tx_byte);
                            pk.r[top_idx(pk.n)].tx_taken = 1'b1;
                            bytes_left_next = bytes_left_reg - 8'd1;
                        end
                        else
                        begin
                            pk = put(pk, F_STOP, 2'd1);
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_BTF_RS:
                    begin
                        pk = put(pk, F_START, 2'd1);
                        phase_next = PH_SB_R;
                    end
                    default: ;
                endcase
            end
        end

        // An item with no action still yields one empty result
        if (pk.n == 3'd0)
        begin
            pk.n = 3'd1;
        end
        for (int k = 0; k < MAX_RES; k++)
        begin
            pk.r[k].busy_res = (phase_next != PH_IDLE);
            pk.r[k].last     = (3'(k) == pk.n - 3'd1);
        end
    end

    // Transfer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            slave_addr_reg <= '0;
            reg_addr_reg   <= '0;
            bytes_left_reg <= '0;
            read_mode_reg  <= 1'b0;
        end
        else if (load)
        begin
            phase_reg      <= phase_next;
            slave_addr_reg <= slave_addr_next;
            reg_addr_reg   <= reg_addr_next;
            bytes_left_reg <= bytes_left_next;
            read_mode_reg  <= read_mode_next;
        end
    end

    // Result stage count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg <= 3'd0;
        end
        else if (load)
        begin
            res_cnt_reg <= pk.n;
        end
        else if (fire_out)
        begin
            res_cnt_reg <= res_cnt_reg - 3'd1;
        end
    end

    // Result stage payload: load a new set, or shift toward slot 0
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= pk.r;
        end
        else if (fire_out)
        begin
            for (int k = 0; k < MAX_RES - 1; k++)
            begin
                res_reg[k] <= res_reg[k+1];
            end
        end
    end

    // Output fields
    assign dr_write_valid = res_reg[0].dr_write_valid;
    assign dr_write_value = res_reg[0].dr_write_value;
    assign gen_start      = res_reg[0].gen_start;
    assign gen_stop       = res_reg[0].gen_stop;
    assign ack_action     = res_reg[0].ack_action;
    assign pos_action     = res_reg[0].pos_action;
    assign buf_irq_action = res_reg[0].buf_irq_action;
    assign rx_valid       = res_reg[0].rx_valid;
    assign rx_byte        = res_reg[0].rx_byte;
    assign tx_taken       = res_reg[0].tx_taken;
    assign busy_res       = res_reg[0].busy_res;
    assign last           = res_reg[0].last;

    // Checks
    a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (res_cnt_reg == 3'd1)))
        else $error("last flag out of step with result count");

    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (res_cnt_reg != 3'd0))
        else $error("decoded item produced no result");

    a_phase_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(phase_reg))
        else $error("phase changed without a decoded item");

    a_busy_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (res_reg[0].busy_res == (phase_reg != PH_IDLE)))
        else $error("busy flag does not match phase");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !load) |=> in_valid_reg)
        else $error("pending item dropped");

endmodule

`default_nettype wire
